// ===== src/dlk_pkg.sv =====
// ----------------------------------------------------------------------------
// dlk_pkg
// shared widths, constants and types of the dual ir lick detector
// ----------------------------------------------------------------------------
package dlk_pkg;

	// ring depth must be a power of two
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	localparam int TIME_W   = 32;
	localparam int SAMPLE_W = 10;
	localparam int PERIOD_W = 16;
	localparam int THR_W    = 11;
	localparam int LEVEL_W  = 12;
	localparam int SUM_W    = SAMPLE_W + RING_AW;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 16;

	localparam logic [SAMPLE_W-1:0]       RING_INIT  = SAMPLE_W'(512);
	localparam logic [SUM_W-1:0]          SUM_RESET  = SUM_W'(512) << RING_AW;
	localparam logic signed [LEVEL_W-1:0] MIN_INIT   = LEVEL_W'(1023);
	localparam logic [PERIOD_W-1:0]       PERIOD_RST = PERIOD_W'(100);
	localparam logic [THR_W-1:0]          THR_RST    = THR_W'(50);

	typedef enum logic [CFG_IW-1:0] {
		CFG_PERIOD    = 2'd0,
		CFG_LEFT_THR  = 2'd1,
		CFG_RIGHT_THR = 2'd2
	} cfg_reg_t;

	typedef logic [SAMPLE_W-1:0]       sample_t;
	typedef logic signed [LEVEL_W-1:0] level_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_ms;
		sample_t           left_sample;
		sample_t           right_sample;
		logic              debug_request;
	} in_item_t;

	typedef struct packed {
		sample_t left_sample;
		sample_t right_sample;
		sample_t left_mean;
		sample_t right_mean;
		logic    debug_request;
	} base_item_t;

	typedef struct packed {
		logic    left_touched;
		logic    right_touched;
		level_t  left_level;
		level_t  right_level;
		sample_t left_baseline;
		sample_t right_baseline;
		level_t  left_min_seen;
		level_t  right_min_seen;
	} result_t;

endpackage

// ===== src/dlk_ifs.sv =====
// ----------------------------------------------------------------------------
// dlk_ifs
// valid/ready channels for sample requests and detector results
// ----------------------------------------------------------------------------
interface dlk_sample_if;
	logic                      valid;
	logic                      ready;
	logic [dlk_pkg::TIME_W-1:0] time_ms;
	dlk_pkg::sample_t          left_sample;
	dlk_pkg::sample_t          right_sample;
	logic                      debug_request;

	modport source (output valid, time_ms, left_sample, right_sample, debug_request,
		input ready);
	modport sink (input valid, time_ms, left_sample, right_sample, debug_request,
		output ready);
endinterface

interface dlk_result_if;
	logic             valid;
	logic             ready;
	logic             left_touched;
	logic             right_touched;
	dlk_pkg::level_t  left_level;
	dlk_pkg::level_t  right_level;
	dlk_pkg::sample_t left_baseline;
	dlk_pkg::sample_t right_baseline;
	dlk_pkg::level_t  left_min_seen;
	dlk_pkg::level_t  right_min_seen;

	modport source (output valid, left_touched, right_touched, left_level, right_level,
		left_baseline, right_baseline, left_min_seen, right_min_seen, input ready);
	modport sink (input valid, left_touched, right_touched, left_level, right_level,
		left_baseline, right_baseline, left_min_seen, right_min_seen, output ready);
endinterface

// ===== src/dual_ir_lick_detector_top.sv =====
// pipeline: an accepted request is registered in item_s1, base_s2, then res_q;
// throughput: one request per cycle unless the result channel stalls; the baseline
// update (period test, ring slot read and running sum) completes within stage s1, ring reads are prefetched
// reset: control, sums, means, minima and config return to their reset values;
// ring entries read as 512 through per-entry valid flops, no clearing pass
// ----------------------------------------------------------------------------
// dual_ir_lick_detector_top
// two channel ir touch detector with moving average baselines
// ----------------------------------------------------------------------------
module dual_ir_lick_detector_top (
	input  logic                        clk,
	input  logic                        arst_n,
	dlk_sample_if.sink                  sample,
	dlk_result_if.source                result,
	input  logic                        cfg_we,
	input  logic [dlk_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [dlk_pkg::CFG_DW-1:0]  cfg_wdata
);

	logic [dlk_pkg::PERIOD_W-1:0] period_q;
	logic [dlk_pkg::THR_W-1:0]    lthr_q;
	logic [dlk_pkg::THR_W-1:0]    rthr_q;

	dlk_pkg::in_item_t   item_s1;
	logic                vld_s1;
	dlk_pkg::base_item_t base_d;
	dlk_pkg::base_item_t base_s2;
	logic                vld_s2;
	dlk_pkg::result_t    res_d;
	dlk_pkg::result_t    res_q;
	logic                res_vld_q;

	logic en_out;
	logic en2;
	logic en1;

	assign en_out = !res_vld_q || result.ready;
	assign en2    = !vld_s2 || en_out;
	assign en1    = !vld_s1 || en2;
	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= dlk_pkg::PERIOD_RST;
			lthr_q   <= dlk_pkg::THR_RST;
			rthr_q   <= dlk_pkg::THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlk_pkg::CFG_PERIOD:    period_q <= cfg_wdata;
				dlk_pkg::CFG_LEFT_THR:  lthr_q   <= cfg_wdata[dlk_pkg::THR_W-1:0];
				dlk_pkg::CFG_RIGHT_THR: rthr_q   <= cfg_wdata[dlk_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= sample.valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en_out) begin
				res_vld_q <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1.time_ms       <= sample.time_ms;
			item_s1.left_sample   <= sample.left_sample;
			item_s1.right_sample  <= sample.right_sample;
			item_s1.debug_request <= sample.debug_request;
		end
		if (en2) begin
			base_s2 <= base_d;
		end
		if (en_out) begin
			res_q <= res_d;
		end
	end

	dlk_baseline u_baseline (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (vld_s1 && en2),
		.item   (item_s1),
		.period (period_q),
		.base   (base_d)
	);

	dlk_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (vld_s2 && en_out),
		.base      (base_s2),
		.left_thr  (lthr_q),
		.right_thr (rthr_q),
		.res       (res_d)
	);

	assign result.valid          = res_vld_q;
	assign result.left_touched   = res_q.left_touched;
	assign result.right_touched  = res_q.right_touched;
	assign result.left_level     = res_q.left_level;
	assign result.right_level    = res_q.right_level;
	assign result.left_baseline  = res_q.left_baseline;
	assign result.right_baseline = res_q.right_baseline;
	assign result.left_min_seen  = res_q.left_min_seen;
	assign result.right_min_seen = res_q.right_min_seen;

endmodule

// ===== src/dlk_ram.sv =====
// ----------------------------------------------------------------------------
// dlk_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module dlk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/dlk_baseline.sv =====
// ----------------------------------------------------------------------------
// dlk_baseline
// baseline rings, running sums and means, updated once per period
// ----------------------------------------------------------------------------
module dlk_baseline (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  dlk_pkg::in_item_t             item,
	input  logic [dlk_pkg::PERIOD_W-1:0]  period,
	output dlk_pkg::base_item_t           base
);

	logic [dlk_pkg::RING_AW-1:0]  pos_q;
	logic [dlk_pkg::RING_AW-1:0]  pos_nxt;
	logic [dlk_pkg::RING_AW-1:0]  pos_d;
	logic [dlk_pkg::SUM_W-1:0]    lsum_q;
	logic [dlk_pkg::SUM_W-1:0]    rsum_q;
	logic [dlk_pkg::SUM_W-1:0]    lsum_new;
	logic [dlk_pkg::SUM_W-1:0]    rsum_new;
	dlk_pkg::sample_t             lmean_q;
	dlk_pkg::sample_t             rmean_q;
	logic [dlk_pkg::TIME_W-1:0]   last_q;
	logic [dlk_pkg::TIME_W-1:0]   deadline;
	logic [dlk_pkg::RING_DEPTH-1:0] vld_q;
	dlk_pkg::sample_t             l_rd;
	dlk_pkg::sample_t             r_rd;
	dlk_pkg::sample_t             l_old;
	dlk_pkg::sample_t             r_old;
	logic                         upd;

	assign deadline = last_q + dlk_pkg::TIME_W'(period);
	assign upd      = fire && (deadline < item.time_ms);
	assign pos_nxt  = (pos_q == dlk_pkg::RING_AW'(dlk_pkg::RING_DEPTH - 1)) ? '0
		: pos_q + 1'b1;
	assign pos_d    = upd ? pos_nxt : pos_q;

	// entries never written read as the reset fill
	assign l_old = vld_q[pos_q] ? l_rd : dlk_pkg::RING_INIT;
	assign r_old = vld_q[pos_q] ? r_rd : dlk_pkg::RING_INIT;

	assign lsum_new = lsum_q - dlk_pkg::SUM_W'(l_old) + dlk_pkg::SUM_W'(item.left_sample);
	assign rsum_new = rsum_q - dlk_pkg::SUM_W'(r_old) + dlk_pkg::SUM_W'(item.right_sample);

	// read ahead at the position the next update will use
	dlk_ram #(.WIDTH(dlk_pkg::SAMPLE_W), .DEPTH(dlk_pkg::RING_DEPTH)) u_left_ring (
		.clk   (clk),
		.we    (upd),
		.waddr (pos_q),
		.wdata (item.left_sample),
		.raddr (pos_d),
		.rdata (l_rd)
	);

	dlk_ram #(.WIDTH(dlk_pkg::SAMPLE_W), .DEPTH(dlk_pkg::RING_DEPTH)) u_right_ring (
		.clk   (clk),
		.we    (upd),
		.waddr (pos_q),
		.wdata (item.right_sample),
		.raddr (pos_d),
		.rdata (r_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			lsum_q  <= dlk_pkg::SUM_RESET;
			rsum_q  <= dlk_pkg::SUM_RESET;
			lmean_q <= '0;
			rmean_q <= '0;
			last_q  <= '0;
			vld_q   <= '0;
		end else if (upd) begin
			pos_q         <= pos_nxt;
			lsum_q        <= lsum_new;
			rsum_q        <= rsum_new;
			lmean_q       <= lsum_new[dlk_pkg::SUM_W-1:dlk_pkg::RING_AW];
			rmean_q       <= rsum_new[dlk_pkg::SUM_W-1:dlk_pkg::RING_AW];
			last_q        <= item.time_ms;
			vld_q[pos_q]  <= 1'b1;
		end
	end

	always_comb begin
		base.left_sample   = item.left_sample;
		base.right_sample  = item.right_sample;
		base.left_mean     = upd ? lsum_new[dlk_pkg::SUM_W-1:dlk_pkg::RING_AW] : lmean_q;
		base.right_mean    = upd ? rsum_new[dlk_pkg::SUM_W-1:dlk_pkg::RING_AW] : rmean_q;
		base.debug_request = item.debug_request;
	end

endmodule

// ===== src/dlk_level.sv =====
// ----------------------------------------------------------------------------
// dlk_level
// cross-normalized levels, touch decisions and minimum tracking
// ----------------------------------------------------------------------------
module dlk_level (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  dlk_pkg::base_item_t        base,
	input  logic [dlk_pkg::THR_W-1:0]  left_thr,
	input  logic [dlk_pkg::THR_W-1:0]  right_thr,
	output dlk_pkg::result_t           res
);

	dlk_pkg::level_t             lmin_q;
	dlk_pkg::level_t             rmin_q;
	dlk_pkg::level_t             llev;
	dlk_pkg::level_t             rlev;
	dlk_pkg::level_t             lmin_cur;
	dlk_pkg::level_t             rmin_cur;
	logic signed [dlk_pkg::LEVEL_W:0] lbound;
	logic signed [dlk_pkg::LEVEL_W:0] rbound;

	assign llev = $signed({2'b00, base.left_sample}) - $signed({2'b00, base.right_sample})
		+ $signed({2'b00, base.right_mean});
	assign rlev = $signed({2'b00, base.right_sample}) - $signed({2'b00, base.left_sample})
		+ $signed({2'b00, base.left_mean});

	assign lbound = $signed({3'b000, base.left_mean}) - $signed({2'b00, left_thr});
	assign rbound = $signed({3'b000, base.right_mean}) - $signed({2'b00, right_thr});

	assign lmin_cur = base.debug_request ? dlk_pkg::MIN_INIT : lmin_q;
	assign rmin_cur = base.debug_request ? dlk_pkg::MIN_INIT : rmin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lmin_q <= dlk_pkg::MIN_INIT;
			rmin_q <= dlk_pkg::MIN_INIT;
		end else if (fire) begin
			lmin_q <= (llev < lmin_cur) ? llev : lmin_cur;
			rmin_q <= (rlev < rmin_cur) ? rlev : rmin_cur;
		end
	end

	always_comb begin
		res.left_touched   = $signed({llev[dlk_pkg::LEVEL_W-1], llev}) < lbound;
		res.right_touched  = $signed({rlev[dlk_pkg::LEVEL_W-1], rlev}) < rbound;
		res.left_level     = llev;
		res.right_level    = rlev;
		res.left_baseline  = base.left_mean;
		res.right_baseline = base.right_mean;
		res.left_min_seen  = lmin_q;
		res.right_min_seen = rmin_q;
	end

endmodule

// ===== src/dlk_checker.sv =====
// ----------------------------------------------------------------------------
// dlk_checker
// port level checks on the detector result channel
// ----------------------------------------------------------------------------
module dlk_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input dlk_pkg::level_t  left_level,
	input dlk_pkg::level_t  right_level,
	input dlk_pkg::sample_t left_baseline,
	input dlk_pkg::sample_t right_baseline,
	input dlk_pkg::level_t  left_min_seen,
	input dlk_pkg::level_t  right_min_seen
);

	logic [dlk_pkg::LEVEL_W-1:0] level_sum;
	logic [dlk_pkg::LEVEL_W-1:0] base_sum;

	assign level_sum = left_level + right_level;
	assign base_sum  = {2'b00, left_baseline} + {2'b00, right_baseline};

	// stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// cross normalization: the two levels add up to the two baselines
	a_level_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_sum == base_sum)
		else $error("levels inconsistent with baselines");

	// minima never rise above their start value
	a_min_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_min_seen <= dlk_pkg::MIN_INIT)
			&& (right_min_seen <= dlk_pkg::MIN_INIT))
		else $error("minimum above start value");

endmodule

bind dual_ir_lick_detector_top dlk_checker u_dlk_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.left_level     (result.left_level),
	.right_level    (result.right_level),
	.left_baseline  (result.left_baseline),
	.right_baseline (result.right_baseline),
	.left_min_seen  (result.left_min_seen),
	.right_min_seen (result.right_min_seen)
);

// ===== sim/dual_ir_lick_detector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_ir_lick_detector_top_tb
// Self-checking bench for the two channel ir touch detector. A scoreboard
// keeps its own copy of the baseline rings, running sums, means and minima,
// predicts one result per accepted sample request and compares every result
// field by field. Directed requests cover the sample extremes, the period test
// across the time wrap, the zero means before the first update and debug
// resets; random phases follow under several register settings, with random
// idling on both channels, a long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
module dual_ir_lick_detector_top_tb;

	localparam logic [dlk_pkg::CFG_IW-1:0] CFG_UNUSED  = 2'd3;
	localparam int                         CYCLE_LIMIT = 200000;
	localparam int                         PHASE_ITEMS = 155;
	localparam int                         NUM_PHASES  = 6;

	class lick_scoreboard;
		logic [dlk_pkg::PERIOD_W-1:0] period;
		logic [dlk_pkg::THR_W-1:0]    l_thr;
		logic [dlk_pkg::THR_W-1:0]    r_thr;
		int                           l_hist [dlk_pkg::RING_DEPTH];
		int                           r_hist [dlk_pkg::RING_DEPTH];
		int                           slot;
		int                           l_acc;
		int                           r_acc;
		int                           l_avg;
		int                           r_avg;
		logic [dlk_pkg::TIME_W-1:0]   stamp;
		int                           l_low;
		int                           r_low;
		dlk_pkg::result_t             due_results [$];
		int                           errors;

		function new();
			for (int i = 0; i < dlk_pkg::RING_DEPTH; i++) begin
				l_hist[i] = 512;
				r_hist[i] = 512;
			end
			slot   = 0;
			l_acc  = 512 * dlk_pkg::RING_DEPTH;
			r_acc  = 512 * dlk_pkg::RING_DEPTH;
			l_avg  = 0;
			r_avg  = 0;
			stamp  = '0;
			l_low  = 1023;
			r_low  = 1023;
			period = dlk_pkg::PERIOD_RST;
			l_thr  = dlk_pkg::THR_RST;
			r_thr  = dlk_pkg::THR_RST;
			errors = 0;
		endfunction

		function void write_reg(logic [dlk_pkg::CFG_IW-1:0] idx,
			logic [dlk_pkg::CFG_DW-1:0] d);
			case (idx)
				dlk_pkg::CFG_PERIOD:    period = d[dlk_pkg::PERIOD_W-1:0];
				dlk_pkg::CFG_LEFT_THR:  l_thr  = d[dlk_pkg::THR_W-1:0];
				dlk_pkg::CFG_RIGHT_THR: r_thr  = d[dlk_pkg::THR_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(dlk_pkg::in_item_t it);
			logic [dlk_pkg::TIME_W-1:0] deadline;
			int                         lv;
			int                         rv;
			int                         llev;
			int                         rlev;
			dlk_pkg::result_t           want;
			deadline = stamp + dlk_pkg::TIME_W'(period);
			if (deadline < it.time_ms) begin
				stamp = it.time_ms;
				l_acc = l_acc - l_hist[slot] + int'(it.left_sample);
				r_acc = r_acc - r_hist[slot] + int'(it.right_sample);
				l_hist[slot] = int'(it.left_sample);
				r_hist[slot] = int'(it.right_sample);
				slot  = (slot + 1) % dlk_pkg::RING_DEPTH;
				l_avg = l_acc / dlk_pkg::RING_DEPTH;
				r_avg = r_acc / dlk_pkg::RING_DEPTH;
			end
			lv   = int'(it.left_sample);
			rv   = int'(it.right_sample);
			llev = lv - (rv - r_avg);
			rlev = rv - (lv - l_avg);
			want.left_min_seen  = dlk_pkg::level_t'(l_low);
			want.right_min_seen = dlk_pkg::level_t'(r_low);
			if (it.debug_request) begin
				l_low = 1023;
				r_low = 1023;
			end
			if (llev < l_low)
				l_low = llev;
			if (rlev < r_low)
				r_low = rlev;
			want.left_touched   = llev < l_avg - int'(l_thr);
			want.right_touched  = rlev < r_avg - int'(r_thr);
			want.left_level     = dlk_pkg::level_t'(llev);
			want.right_level    = dlk_pkg::level_t'(rlev);
			want.left_baseline  = dlk_pkg::sample_t'(l_avg);
			want.right_baseline = dlk_pkg::sample_t'(r_avg);
			due_results.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns: %s", $time, msg);
		endtask

		task cmp_field(string name, logic [dlk_pkg::LEVEL_W-1:0] got,
			logic [dlk_pkg::LEVEL_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_result(dlk_pkg::result_t got);
			dlk_pkg::result_t want;
			if (due_results.size() == 0) begin
				report("result with no request pending");
			end else begin
				want = due_results.pop_front();
				cmp_field("left_touched", dlk_pkg::LEVEL_W'(got.left_touched),
					dlk_pkg::LEVEL_W'(want.left_touched));
				cmp_field("right_touched", dlk_pkg::LEVEL_W'(got.right_touched),
					dlk_pkg::LEVEL_W'(want.right_touched));
				cmp_field("left_level", got.left_level, want.left_level);
				cmp_field("right_level", got.right_level, want.right_level);
				cmp_field("left_baseline", dlk_pkg::LEVEL_W'(got.left_baseline),
					dlk_pkg::LEVEL_W'(want.left_baseline));
				cmp_field("right_baseline", dlk_pkg::LEVEL_W'(got.right_baseline),
					dlk_pkg::LEVEL_W'(want.right_baseline));
				cmp_field("left_min_seen", got.left_min_seen, want.left_min_seen);
				cmp_field("right_min_seen", got.right_min_seen, want.right_min_seen);
			end
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [dlk_pkg::CFG_IW-1:0] cfg_index;
	logic [dlk_pkg::CFG_DW-1:0] cfg_wdata;
	bit                         calm;
	bit                         hold_req;
	int unsigned                cycle_count = 0;
	lick_scoreboard             sb = new();

	dlk_sample_if sample_ch ();
	dlk_result_if result_ch ();

	dual_ir_lick_detector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dual_ir_lick_detector_top: mismatch");
			$finish;
		end
	end

	task automatic send_request(dlk_pkg::in_item_t it);
		while (!calm && $urandom_range(0, 99) < 9) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid         <= 1'b1;
		sample_ch.time_ms       <= it.time_ms;
		sample_ch.left_sample   <= it.left_sample;
		sample_ch.right_sample  <= it.right_sample;
		sample_ch.debug_request <= it.debug_request;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		sb.note_request(it);
		@(negedge clk);
	endtask

	task automatic send_fields(logic [dlk_pkg::TIME_W-1:0] t, int ls, int rs, int dbg);
		dlk_pkg::in_item_t it;
		it.time_ms       = t;
		it.left_sample   = dlk_pkg::sample_t'(ls);
		it.right_sample  = dlk_pkg::sample_t'(rs);
		it.debug_request = (dbg != 0);
		send_request(it);
	endtask

	task automatic write_reg(logic [dlk_pkg::CFG_IW-1:0] idx, logic [dlk_pkg::CFG_DW-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
	endtask

	// result channel: random backpressure and one long hold-off
	initial begin : result_sink
		int unsigned      hold_cnt;
		bit               hold_done;
		dlk_pkg::result_t got;
		hold_cnt = 0;
		hold_done = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_cnt  = 400;
				hold_done = 1;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				result_ch.ready <= 1'b0;
			end else if (calm) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= 9);
			end
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.left_touched   = result_ch.left_touched;
				got.right_touched  = result_ch.right_touched;
				got.left_level     = result_ch.left_level;
				got.right_level    = result_ch.right_level;
				got.left_baseline  = result_ch.left_baseline;
				got.right_baseline = result_ch.right_baseline;
				got.left_min_seen  = result_ch.left_min_seen;
				got.right_min_seen = result_ch.right_min_seen;
				sb.check_result(got);
			end
		end
	end

	initial begin : stimulus
		logic [dlk_pkg::TIME_W-1:0]   now_ms;
		logic [dlk_pkg::PERIOD_W-1:0] per;
		int unsigned                  span;
		int                           r;
		int                           c;
		int                           ls;
		int                           rs;
		dlk_pkg::in_item_t            it;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = dlk_pkg::CFG_PERIOD;
		cfg_wdata               = '0;
		sample_ch.valid         = 1'b0;
		sample_ch.time_ms       = '0;
		sample_ch.left_sample   = '0;
		sample_ch.right_sample  = '0;
		sample_ch.debug_request = 1'b0;
		calm                    = 0;
		hold_req                = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero means and period boundary at reset settings
		send_fields(32'd0, 0, 0, 0);
		send_fields(32'd100, 1023, 1023, 0);
		send_fields(32'd50, 1023, 0, 1);
		send_fields(32'd100, 0, 1023, 0);
		send_fields(32'd101, 512, 512, 0);
		send_fields(32'd150, 1023, 1023, 0);
		send_fields(32'd201, 0, 0, 0);
		send_fields(32'd202, 400, 600, 0);
		send_fields(32'd203, 0, 1023, 1);
		send_fields(32'd204, 1023, 0, 1);
		send_fields(32'd205, 300, 300, 0);
		// deadline wraps past the top of the time range
		send_fields(32'hFFFF_FFFF, 1023, 1023, 0);
		send_fields(32'h0000_0010, 512, 512, 0);
		send_fields(32'd99, 600, 500, 0);
		send_fields(32'd100, 100, 900, 0);
		send_fields(32'hAAAA_5555, 900, 100, 1);
		send_fields(32'h5555_AAAA, 0, 0, 0);
		send_fields(32'h0, 1023, 1023, 1);
		now_ms = 32'h5555_AAAA;

		for (int phase = 1; phase <= NUM_PHASES; phase++) begin
			sample_ch.valid <= 1'b0;
			while (sb.due_results.size() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
			calm = (phase == 1);
			case (phase)
				1: begin
					write_reg(dlk_pkg::CFG_PERIOD, 16'd0);
					write_reg(dlk_pkg::CFG_LEFT_THR, 16'd0);
					write_reg(dlk_pkg::CFG_RIGHT_THR, 16'd0);
				end
				2: begin
					write_reg(dlk_pkg::CFG_PERIOD, 16'hFFFF);
					write_reg(dlk_pkg::CFG_LEFT_THR, 16'hFFFF);
					write_reg(dlk_pkg::CFG_RIGHT_THR, 16'hFFFF);
				end
				3: begin
					write_reg(dlk_pkg::CFG_PERIOD, dlk_pkg::CFG_DW'($urandom_range(0, 20)));
					write_reg(dlk_pkg::CFG_LEFT_THR, dlk_pkg::CFG_DW'($urandom_range(0, 300)));
					write_reg(dlk_pkg::CFG_RIGHT_THR, dlk_pkg::CFG_DW'($urandom_range(0, 300)));
					write_reg(CFG_UNUSED, dlk_pkg::CFG_DW'($urandom()));
				end
				4: begin
					write_reg(dlk_pkg::CFG_PERIOD, dlk_pkg::CFG_DW'($urandom()));
					write_reg(dlk_pkg::CFG_LEFT_THR, dlk_pkg::CFG_DW'($urandom()));
					write_reg(dlk_pkg::CFG_RIGHT_THR, dlk_pkg::CFG_DW'($urandom()));
				end
				5: begin
					write_reg(dlk_pkg::CFG_PERIOD, 16'd1);
					write_reg(dlk_pkg::CFG_LEFT_THR, 16'd2047);
					write_reg(dlk_pkg::CFG_RIGHT_THR, 16'd0);
					write_reg(CFG_UNUSED, 16'hFFFF);
				end
				default: begin
					write_reg(dlk_pkg::CFG_PERIOD, dlk_pkg::CFG_DW'($urandom_range(0, 200)));
					write_reg(dlk_pkg::CFG_LEFT_THR, dlk_pkg::CFG_DW'($urandom_range(0, 150)));
					write_reg(dlk_pkg::CFG_RIGHT_THR, dlk_pkg::CFG_DW'($urandom_range(0, 150)));
				end
			endcase
			cfg_we <= 1'b0;
			@(negedge clk);
			if (phase == 2)
				hold_req = 1;
			per = sb.period;
			c = $urandom_range(150, 870);

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					now_ms = $urandom();
				end else if (r >= 20) begin
					span = 32'(per);
					span = span + span / 2 + 3;
					now_ms = now_ms + $urandom_range(0, span);
				end
				if ($urandom_range(0, 99) == 0)
					c = $urandom_range(150, 870);
				r = $urandom_range(0, 99);
				if (r < 10) begin
					ls = $urandom_range(0, 1) * 1023;
					rs = $urandom_range(0, 1) * 1023;
				end else if (r < 70) begin
					ls = c + $urandom_range(0, 80) - 40;
					rs = c + $urandom_range(0, 80) - 40;
					if ($urandom_range(0, 3) == 0)
						ls -= $urandom_range(0, 400);
					else if ($urandom_range(0, 2) == 0)
						rs -= $urandom_range(0, 400);
				end else begin
					ls = $urandom_range(0, 1023);
					rs = $urandom_range(0, 1023);
				end
				if (ls < 0) ls = 0;
				if (ls > 1023) ls = 1023;
				if (rs < 0) rs = 0;
				if (rs > 1023) rs = 1023;
				it.time_ms       = now_ms;
				it.left_sample   = dlk_pkg::sample_t'(ls);
				it.right_sample  = dlk_pkg::sample_t'(rs);
				it.debug_request = ($urandom_range(0, 99) < 8);
				send_request(it);
			end
		end

		sample_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("dual_ir_lick_detector_top: match");
		else
			$display("dual_ir_lick_detector_top: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dlk_pkg.sv
src/dlk_ifs.sv
src/dlk_ram.sv
src/dlk_baseline.sv
src/dlk_level.sv
src/dual_ir_lick_detector_top.sv
src/dlk_checker.sv
sim/dual_ir_lick_detector_top_tb.sv
